/* design/pdpw_pkg.sv */
// Shared types and constants for the parallel display pixel writer.
package pdpw_pkg;

    localparam int CountBits = 24;

    typedef logic [CountBits-1:0] t_count;

    typedef enum logic [1:0] {
        OP_DRAW_PIXEL  = 2'd0,
        OP_SET_WINDOW  = 2'd1,
        OP_START_FILL  = 2'd2,
        OP_FILL_NEXT   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_COLUMN_CMD    = 3'd2,
        CFG_PAGE_CMD      = 3'd3,
        CFG_MEMWR_CMD     = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_PIXEL      = 2'd0,
        KIND_WINDOW     = 2'd1,
        KIND_FILL_START = 2'd2,
        KIND_FILL_NEXT  = 2'd3
    } t_kind;

    typedef logic [3:0] t_pos;

    localparam t_pos POS_COL_CMD  = 4'd0;
    localparam t_pos POS_XS_HI    = 4'd1;
    localparam t_pos POS_XS_LO    = 4'd2;
    localparam t_pos POS_XE_HI    = 4'd3;
    localparam t_pos POS_XE_LO    = 4'd4;
    localparam t_pos POS_PAGE_CMD = 4'd5;
    localparam t_pos POS_YS_HI    = 4'd6;
    localparam t_pos POS_YS_LO    = 4'd7;
    localparam t_pos POS_YE_HI    = 4'd8;
    localparam t_pos POS_YE_LO    = 4'd9;
    localparam t_pos POS_MEMWR    = 4'd10;
    localparam t_pos POS_COLOR_HI = 4'd11;
    localparam t_pos POS_COLOR_LO = 4'd12;

    localparam logic [15:0] ResetWidth   = 16'd320;
    localparam logic [15:0] ResetHeight  = 16'd480;
    localparam logic [7:0]  ResetColCmd  = 8'h2A;
    localparam logic [7:0]  ResetPageCmd = 8'h2B;
    localparam logic [7:0]  ResetMemwr   = 8'h2C;

    typedef struct packed {
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic [7:0]  column_cmd;
        logic [7:0]  page_cmd;
        logic [7:0]  memwr_cmd;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] xs;
        logic [15:0] ys;
        logic [15:0] xe;
        logic [15:0] ye;
        logic [15:0] color;
        logic        release_last;
    } t_desc;

endpackage

/* design/parallel_display_pixel_writer.sv */
// Top level: config registers, request intake, descriptor queue and byte sequencer.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | opcode, x/y start, x/y end, color, count
//  out     | output    | o_out_valid / i_out_ready  | bus byte, command flag, release, last
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One bus byte leaves per cycle unless the output stalls: draw pixel 13 bytes, set window 10,
// start fill 3, fill next 2; dropped requests are taken at the intake and emit no bytes.
// The byte sequencer sets the rate; the queue holds up to two descriptors, the one being walked included.
// Reset is synchronous and restores the default register values and an empty pipe.
// Output stalls hold the output register and back-fill the queue, then drop o_in_ready.
module parallel_display_pixel_writer
    import pdpw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [15:0] i_x_start,
    input  logic signed [15:0] i_y_start,
    input  logic [15:0]        i_x_end,
    input  logic [15:0]        i_y_end,
    input  logic [15:0]        i_pixel_color,
    input  logic [23:0]        i_pixel_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_bus_byte,
    output logic               o_is_command,
    output logic               o_select_release,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_cfg  r_cfg;
    logic  queue_full;
    logic  push;
    t_desc push_desc;
    logic  head_valid;
    t_desc head_desc;
    logic  pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= ResetWidth;
            r_cfg.screen_height <= ResetHeight;
            r_cfg.column_cmd    <= ResetColCmd;
            r_cfg.page_cmd      <= ResetPageCmd;
            r_cfg.memwr_cmd     <= ResetMemwr;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data;
                CFG_COLUMN_CMD:    r_cfg.column_cmd    <= i_cfg_data[7:0];
                CFG_PAGE_CMD:      r_cfg.page_cmd      <= i_cfg_data[7:0];
                CFG_MEMWR_CMD:     r_cfg.memwr_cmd     <= i_cfg_data[7:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    pdpw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_opcode      (i_opcode),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_pixel_color (i_pixel_color),
        .i_pixel_count (i_pixel_count),
        .i_cfg         (r_cfg),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_desc        (push_desc)
    );

    pdpw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_desc),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_desc)
    );

    pdpw_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (head_valid),
        .i_head           (head_desc),
        .o_pop            (pop),
        .i_cfg            (r_cfg),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_bus_byte       (o_bus_byte),
        .o_is_command     (o_is_command),
        .o_select_release (o_select_release),
        .o_last           (o_last)
    );

endmodule

/* design/pdpw_front.sv */
// Request intake: clipping, fill bookkeeping and descriptor build.
module pdpw_front
    import pdpw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [15:0] i_x_start,
    input  logic signed [15:0] i_y_start,
    input  logic [15:0]        i_x_end,
    input  logic [15:0]        i_y_end,
    input  logic [15:0]        i_pixel_color,
    input  logic [23:0]        i_pixel_count,
    input  t_cfg               i_cfg,
    input  logic               i_queue_full,
    output logic               o_push,
    output t_desc              o_desc
);

    t_count      r_fill_remaining, n_fill_remaining;
    logic [15:0] r_fill_color, n_fill_color;
    logic        r_fill_active, n_fill_active;

    logic        accept;
    logic        clipped;
    t_count      count;
    t_count      start_remaining;
    t_count      next_remaining;
    logic [15:0] xs_u;
    logic [15:0] ys_u;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    assign xs_u    = $unsigned(i_x_start);
    assign ys_u    = $unsigned(i_y_start);
    assign clipped = xs_u[15] || ys_u[15] ||
                     (xs_u >= i_cfg.screen_width) || (ys_u >= i_cfg.screen_height);

    assign count           = t_count'(i_pixel_count);
    assign start_remaining = (count == '0) ? '0 : t_count'(count - 1'b1);
    assign next_remaining  = t_count'(r_fill_remaining - 1'b1);

    always_comb begin
        n_fill_remaining = r_fill_remaining;
        n_fill_color     = r_fill_color;
        n_fill_active    = r_fill_active;
        o_push           = 1'b0;
        o_desc.kind         = KIND_WINDOW;
        o_desc.xs           = xs_u;
        o_desc.ys           = ys_u;
        o_desc.xe           = i_x_end;
        o_desc.ye           = i_y_end;
        o_desc.color        = i_pixel_color;
        o_desc.release_last = 1'b1;
        case (t_opcode'(i_opcode))
            OP_DRAW_PIXEL: begin
                o_desc.kind = KIND_PIXEL;
                o_desc.xe   = i_cfg.screen_width - 16'd1;
                o_desc.ye   = i_cfg.screen_height - 16'd1;
                if (accept && !clipped) begin
                    o_push           = 1'b1;
                    n_fill_remaining = '0;
                    n_fill_active    = 1'b0;
                end
            end
            OP_SET_WINDOW: begin
                if (accept) begin
                    o_push           = 1'b1;
                    n_fill_remaining = '0;
                    n_fill_active    = 1'b0;
                end
            end
            OP_START_FILL: begin
                o_desc.kind         = KIND_FILL_START;
                o_desc.release_last = (start_remaining == '0);
                if (accept) begin
                    o_push           = 1'b1;
                    n_fill_color     = i_pixel_color;
                    n_fill_remaining = start_remaining;
                    n_fill_active    = (start_remaining != '0);
                end
            end
            OP_FILL_NEXT: begin
                o_desc.kind         = KIND_FILL_NEXT;
                o_desc.color        = r_fill_color;
                o_desc.release_last = (next_remaining == '0);
                if (accept && r_fill_active) begin
                    o_push           = 1'b1;
                    n_fill_remaining = next_remaining;
                    n_fill_active    = (next_remaining != '0);
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_remaining <= '0;
            r_fill_color     <= '0;
            r_fill_active    <= 1'b0;
        end else begin
            r_fill_remaining <= n_fill_remaining;
            r_fill_color     <= n_fill_color;
            r_fill_active    <= n_fill_active;
        end
    end

endmodule

/* design/pdpw_queue.sv */
// Two-entry descriptor queue between intake and byte sequencer.
module pdpw_queue
    import pdpw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_data
);

    t_desc      r_entry [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_fill, n_fill;
    logic       do_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_entry[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill + {1'b0, i_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

/* design/pdpw_back.sv */
// Byte sequencer: walks a descriptor one bus byte per cycle, unless stalled, into the output register.
module pdpw_back
    import pdpw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_desc       i_head,
    output logic        o_pop,
    input  t_cfg        i_cfg,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_bus_byte,
    output logic        o_is_command,
    output logic        o_select_release,
    output logic        o_last
);

    logic       r_active, n_active;
    t_pos       r_pos, n_pos;
    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_cmd;
    logic       r_rel;
    logic       r_last;

    t_pos       start_pos;
    t_pos       cur_pos;
    logic       advance;
    logic       emit;
    logic [7:0] sel_byte;
    logic       sel_cmd;
    logic       sel_rel;
    logic       sel_last;

    always_comb begin
        case (i_head.kind)
            KIND_FILL_START: start_pos = POS_MEMWR;
            KIND_FILL_NEXT:  start_pos = POS_COLOR_HI;
            default:         start_pos = POS_COL_CMD;
        endcase
    end

    assign cur_pos = r_active ? r_pos : start_pos;
    assign advance = !r_valid || i_ready;
    assign emit    = advance && i_head_valid;

    always_comb begin
        sel_cmd = 1'b0;
        sel_rel = 1'b0;
        case (cur_pos)
            POS_COL_CMD: begin
                sel_byte = i_cfg.column_cmd;
                sel_cmd  = 1'b1;
            end
            POS_XS_HI: sel_byte = i_head.xs[15:8];
            POS_XS_LO: sel_byte = i_head.xs[7:0];
            POS_XE_HI: sel_byte = i_head.xe[15:8];
            POS_XE_LO: begin
                sel_byte = i_head.xe[7:0];
                sel_rel  = 1'b1;
            end
            POS_PAGE_CMD: begin
                sel_byte = i_cfg.page_cmd;
                sel_cmd  = 1'b1;
            end
            POS_YS_HI: sel_byte = i_head.ys[15:8];
            POS_YS_LO: sel_byte = i_head.ys[7:0];
            POS_YE_HI: sel_byte = i_head.ye[15:8];
            POS_YE_LO: begin
                sel_byte = i_head.ye[7:0];
                sel_rel  = 1'b1;
            end
            POS_MEMWR: begin
                sel_byte = i_cfg.memwr_cmd;
                sel_cmd  = 1'b1;
            end
            POS_COLOR_HI: sel_byte = i_head.color[15:8];
            POS_COLOR_LO: begin
                sel_byte = i_head.color[7:0];
                sel_rel  = i_head.release_last;
            end
            default: sel_byte = 8'h00;
        endcase
        if (i_head.kind == KIND_WINDOW) begin
            sel_last = (cur_pos == POS_YE_LO);
        end else begin
            sel_last = (cur_pos == POS_COLOR_LO);
        end
    end

    assign o_pop = emit && sel_last;

    always_comb begin
        n_active = r_active;
        n_pos    = r_pos;
        n_valid  = r_valid;
        if (emit) begin
            n_valid  = 1'b1;
            n_active = !sel_last;
            n_pos    = cur_pos + 4'd1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= sel_byte;
            r_cmd  <= sel_cmd;
            r_rel  <= sel_rel;
            r_last <= sel_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= POS_COL_CMD;
            r_valid  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_pos    <= n_pos;
            r_valid  <= n_valid;
        end
    end

    assign o_valid          = r_valid;
    assign o_bus_byte       = r_byte;
    assign o_is_command     = r_cmd;
    assign o_select_release = r_rel;
    assign o_last           = r_last;

endmodule

/* design/pdpw_checker.sv */
// Port-level checks for the parallel display pixel writer, bound to the top level.
module pdpw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_bus_byte,
    input logic       o_is_command,
    input logic       o_select_release,
    input logic       o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_bus_byte) && $stable(o_is_command)
            && $stable(o_select_release) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_cmd_no_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_command |-> !o_select_release)
        else $error("command beat releases chip select");

    a_cmd_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_command |-> !o_last)
        else $error("command beat marked last");

endmodule

bind parallel_display_pixel_writer pdpw_checker u_pdpw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_bus_byte       (o_bus_byte),
    .o_is_command     (o_is_command),
    .o_select_release (o_select_release),
    .o_last           (o_last)
);
